### hdl/edmtp_pkg.sv
// ----------------------------------------------------------------------------
// Egg-drop planner package
// Table sizes shared by the planner core and its table memory.
// ----------------------------------------------------------------------------
package edmtp_pkg;
  localparam int MaxCars   = 8;
  localparam int MaxLevels = 64;
  localparam int Row       = MaxLevels + 1;
  localparam int Depth     = MaxCars * Row;
  localparam int AddrW     = $clog2(Depth);
endpackage

### hdl/egg_drop_min_tests_planner_core.sv
// ----------------------------------------------------------------------------
// Egg-drop minimal test planner
// Fills the cost/choice/outcome table bottom-up, then traces the plan.
// ----------------------------------------------------------------------------
// Channel | Direction | Handshake
// in      | input     | in_valid / in_stall
// out     | output    | out_valid / out_stall
// Each item holds the block until its last result beat is taken.
// Fill: one memory read pair per compare step, through S_RD, S_WAIT and S_CMP;
// each trace step passes through S_TR, S_TRW and S_OUT.
// Reset clears the sequencer only; the table is rewritten before it is read.
// A stalled output beat holds its fields until taken.
module egg_drop_min_tests_planner_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [3:0] num_cars,
  input  logic [6:0] num_levels,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [6:0] total_tests,
  output logic [6:0] step_index,
  output logic [3:0] cars_left,
  output logic [6:0] test_level,
  output logic [6:0] remaining_level,
  output logic       succeeded,
  output logic       step_valid,
  output logic       last
);
  localparam int Row   = edmtp_pkg::Row;
  localparam int Depth = edmtp_pkg::Depth;
  localparam int AddrW = edmtp_pkg::AddrW;

  typedef enum logic [3:0] {
    S_IDLE, S_CELL, S_RD, S_WAIT, S_CMP, S_WR, S_TOT, S_TOTW, S_TR, S_TRW,
    S_OUT
  } state_t;

  state_t     state;
  logic [3:0] cars, c;
  logic [6:0] levels, n, t, best, bestt, total, rs, idx;
  logic [3:0] rc;
  logic       bestok;
  logic       we;
  logic [AddrW-1:0] waddr, ra, rb;
  logic [14:0] wdata, da, db;

  function automatic logic [AddrW-1:0] slot(input logic [3:0] cc, input logic [6:0] nn);
    logic [AddrW+7:0] s;
    s = (AddrW+8)'(cc - 4'd1) * (AddrW+8)'(Row) + (AddrW+8)'(nn);
    return s[AddrW-1:0];
  endfunction

  edmtp_mem #(.Depth(Depth), .AddrW(AddrW)) u_mem (
    .clk, .we, .waddr, .wdata, .raddr_a(ra), .rdata_a(da), .raddr_b(rb), .rdata_b(db)
  );

  logic [6:0] ok, bad, m;
  assign ok  = da[14:8];
  assign bad = db[14:8];
  assign m   = 7'd1 + ((ok > bad) ? ok : bad);

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      we        <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            cars   <= (num_cars == 4'd0) ? 4'd1 :
                      ({28'd0, num_cars} > edmtp_pkg::MaxCars) ?
                      4'(edmtp_pkg::MaxCars) : num_cars;
            levels <= ({25'd0, num_levels} > edmtp_pkg::MaxLevels) ?
                      7'(edmtp_pkg::MaxLevels) : num_levels;
            c      <= 4'd1;
            n      <= 7'd0;
            state  <= S_CELL;
          end
        end
        S_CELL: begin
          if (n == 7'd0 || n == 7'd1 || c == 4'd1) begin
            we    <= 1'b1;
            waddr <= slot(c, n);
            wdata <= {n, (n == 7'd0) ? 7'd0 : 7'd1, 1'b1};
            state <= S_WR;
          end else begin
            t      <= 7'd1;
            best   <= 7'h7F;
            bestt  <= 7'd1;
            bestok <= 1'b1;
            state  <= S_RD;
          end
        end
        S_RD: begin
          ra    <= slot(c, n - t);
          rb    <= slot(c - 4'd1, t - 7'd1);
          state <= S_WAIT;
        end
        S_WAIT: state <= S_CMP;
        S_CMP: begin
          // Best starts at all ones; costs never reach it, so the first step wins.
          if (m < best || t == 7'd1) begin
            best   <= m;
            bestt  <= t;
            bestok <= (ok >= bad);
          end
          if (t == n) begin
            state <= S_TOT;
          end else begin
            t     <= t + 7'd1;
            state <= S_RD;
          end
        end
        S_TOT: begin
          we    <= 1'b1;
          waddr <= slot(c, n);
          wdata <= {best, bestt, bestok};
          state <= S_WR;
        end
        S_WR: begin
          we <= 1'b0;
          if (n == levels) begin
            if (c == cars) begin
              ra    <= slot(cars, levels);
              state <= S_TOTW;
              idx   <= 7'd0;
            end else begin
              c     <= c + 4'd1;
              n     <= 7'd0;
              state <= S_CELL;
            end
          end else begin
            n     <= n + 7'd1;
            state <= S_CELL;
          end
        end
        S_TOTW: begin
          // Address registered last cycle; the data is sampled in S_TR.
          rc    <= cars;
          rs    <= levels;
          if (levels == 7'd0) begin
            total           <= 7'd0;
            total_tests     <= 7'd0;
            step_index      <= 7'd0;
            cars_left       <= cars;
            test_level      <= 7'd0;
            remaining_level <= 7'd0;
            succeeded       <= 1'b0;
            step_valid      <= 1'b0;
            last            <= 1'b1;
            out_valid       <= 1'b1;
            state           <= S_OUT;
          end else begin
            state <= S_TR;
          end
        end
        S_TR: begin
          if (idx == 7'd0) begin
            total <= da[14:8];
          end
          ra    <= slot(rc, rs);
          state <= S_TRW;
        end
        S_TRW: state <= S_OUT;
        S_OUT: begin
          if (!out_valid) begin
            logic [6:0] tt;
            logic       o;
            if (rs == 7'd1 || rc == 4'd1) begin
              tt = 7'd1;
              o  = 1'b1;
            end else begin
              tt = (da[7:1] < 7'd1) ? 7'd1 : (da[7:1] > rs) ? rs : da[7:1];
              o  = da[0];
            end
            total_tests     <= total;
            step_index      <= idx + 7'd1;
            cars_left       <= rc;
            test_level      <= tt;
            remaining_level <= rs;
            succeeded       <= o;
            step_valid      <= 1'b1;
            idx             <= idx + 7'd1;
            if (o) begin
              rs <= rs - tt;
              last <= (rs == tt) || (idx + 7'd1 == 7'(edmtp_pkg::MaxLevels));
            end else begin
              rc <= rc - 4'd1;
              rs <= tt - 7'd1;
              last <= (tt == 7'd1) || (idx + 7'd1 == 7'(edmtp_pkg::MaxLevels));
            end
            out_valid <= 1'b1;
          end else if (!out_stall) begin
            out_valid <= 1'b0;
            state     <= last ? S_IDLE : S_TR;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) out_valid |-> state == S_OUT)
    else $error("result beat outside output state");
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(step_index)))
    else $error("stalled result beat changed");
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && step_valid) |-> (test_level != 7'd0 && test_level <= remaining_level))
    else $error("test level out of range");
endmodule

### hdl/edmtp_mem.sv
// ----------------------------------------------------------------------------
// Egg-drop planner table memory
// One-port-write, two-port-read memory of cost, choice and outcome entries.
// ----------------------------------------------------------------------------
module edmtp_mem #(
  parameter int Depth = 520,
  parameter int AddrW = 10
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AddrW-1:0] waddr,
  input  logic [14:0]      wdata,
  input  logic [AddrW-1:0] raddr_a,
  output logic [14:0]      rdata_a,
  input  logic [AddrW-1:0] raddr_b,
  output logic [14:0]      rdata_b
);
  logic [14:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end
endmodule
